// ===== design/ufg_pkg.sv =====
package ufg_pkg;

  // Entries held between the front and back parts
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Character codes used by the folding rules
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_QUOTE = 7'h27;
  localparam logic [6:0] CH_BTICK = 7'h60;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_LOW_Z = 7'h7A;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [6:0] CH_A     = 7'h41;
  localparam logic [6:0] CH_C     = 7'h43;
  localparam logic [6:0] CH_E     = 7'h45;
  localparam logic [6:0] CH_I     = 7'h49;
  localparam logic [6:0] CH_N     = 7'h4E;
  localparam logic [6:0] CH_O     = 7'h4F;
  localparam logic [6:0] CH_U     = 7'h55;
  localparam logic [6:0] CH_Y     = 7'h59;

  // Lead and continuation bytes
  localparam logic [7:0] B_LEAD_C3 = 8'hC3;
  localparam logic [7:0] B_LEAD_C5 = 8'hC5;
  localparam logic [7:0] B_LEAD_E2 = 8'hE2;
  localparam logic [7:0] B_CONT_80 = 8'h80;
  localparam logic [7:0] B_LQUOTE  = 8'h98;
  localparam logic [7:0] B_RQUOTE  = 8'h99;
  localparam logic [7:0] B_OE_UP   = 8'h92;
  localparam logic [7:0] B_OE_LOW  = 8'h93;
  localparam logic [7:0] B_AE_UP   = 8'h86;
  localparam logic [7:0] B_AE_LOW  = 8'hA6;

  // What the previous byte left open
  typedef enum logic [2:0] {
    PK_NONE = 3'd0,
    PK_C3   = 3'd1,
    PK_C5   = 3'd2,
    PK_E2   = 3'd3,
    PK_E280 = 3'd4
  } ufg_pend_t;

  // One request: the folded characters caused by one input byte
  typedef struct packed {
    logic [2:0][6:0] chars;
    logic [1:0]      cnt;
    logic            last;
  } ufg_req_t;

  // Oldest request waiting in the queue
  typedef struct packed {
    logic     valid;
    ufg_req_t req;
  } ufg_head_t;

  // Second byte after lead C3
  function automatic logic [6:0] fold_c3(input logic [7:0] b);
    logic [6:0] ch;
    case (b)
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85,
      8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5: ch = CH_A;
      8'h87, 8'hA7: ch = CH_C;
      8'h88, 8'h89, 8'h8A, 8'h8B,
      8'hA8, 8'hA9, 8'hAA, 8'hAB: ch = CH_E;
      8'h8C, 8'h8D, 8'h8E, 8'h8F,
      8'hAC, 8'hAD, 8'hAE, 8'hAF: ch = CH_I;
      8'h91, 8'hB1: ch = CH_N;
      8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
      8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6: ch = CH_O;
      8'h98, 8'hB8, 8'h9F, 8'hBF: ch = CH_Y;
      8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D,
      8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD: ch = CH_U;
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // 5x7 font, top row first; unknown codes get the question mark
  function automatic logic [34:0] glyph_rom(input logic [6:0] ch);
    logic [34:0] g;
    case (ch)
      7'h20: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      7'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      7'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      7'h33: g = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      7'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      7'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      7'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      7'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      7'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      7'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      7'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      7'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      7'h44: g = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      7'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      7'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
      7'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'h4A: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      7'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      7'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      7'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      7'h4E: g = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      7'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      7'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      7'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      7'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      7'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      7'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
      7'h58: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      7'h59: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      7'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      7'h5B: g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      7'h5D: g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
      7'h2D: g = {5'h00, 5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00};
      7'h3A: g = {5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00};
      7'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      default: g = {5'h0E, 5'h11, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04};
    endcase
    return g;
  endfunction

endpackage

// ===== design/ufg_front.sv =====
module ufg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              in_push,
  output logic              in_full,
  input  logic              q_full,
  output logic              req_push,
  output ufg_pkg::ufg_req_t req
);

  ufg_pkg::ufg_pend_t pend_r, pend_nxt;

  logic       accept;
  logic       f_has;
  logic [6:0] f_ch;
  logic [6:0] low_ch;
  logic [6:0] up_ch;
  logic [1:0] pcnt;
  logic       use_fresh;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign low_ch  = in_byte[6:0];

  // ASCII folding: upper case; unprintables, apostrophe and backtick to space
  always_comb begin
    up_ch = low_ch;
    if (low_ch >= ufg_pkg::CH_LOW_A && low_ch <= ufg_pkg::CH_LOW_Z) begin
      up_ch = low_ch - 7'd32;
    end
    if (up_ch < ufg_pkg::CH_SPACE || up_ch == ufg_pkg::CH_DEL ||
        up_ch == ufg_pkg::CH_QUOTE || up_ch == ufg_pkg::CH_BTICK) begin
      up_ch = ufg_pkg::CH_SPACE;
    end
  end

  // Byte taken with nothing open: one char, or open a lead
  always_comb begin
    f_has = 1'b1;
    f_ch  = ufg_pkg::CH_SPACE;
    if (!in_byte[7]) begin
      f_ch = up_ch;
    end else if (!in_last && (in_byte == ufg_pkg::B_LEAD_C3 ||
                              in_byte == ufg_pkg::B_LEAD_C5 ||
                              in_byte == ufg_pkg::B_LEAD_E2)) begin
      f_has = 1'b0;
    end
  end

  // Build the request
  always_comb begin
    req.chars = {ufg_pkg::CH_SPACE, ufg_pkg::CH_SPACE, ufg_pkg::CH_SPACE};
    req.cnt   = 2'd0;
    req.last  = in_last;
    pcnt      = 2'd0;
    use_fresh = 1'b0;
    case (pend_r)
      ufg_pkg::PK_C3: begin
        if (in_byte == ufg_pkg::B_AE_UP || in_byte == ufg_pkg::B_AE_LOW) begin
          req.chars[0] = ufg_pkg::CH_A;
          req.chars[1] = ufg_pkg::CH_E;
          req.cnt      = 2'd2;
        end else begin
          req.chars[0] = ufg_pkg::fold_c3(in_byte);
          req.cnt      = 2'd1;
        end
      end
      ufg_pkg::PK_C5: begin
        if (in_byte == ufg_pkg::B_OE_UP || in_byte == ufg_pkg::B_OE_LOW) begin
          req.chars[0] = ufg_pkg::CH_O;
          req.chars[1] = ufg_pkg::CH_E;
          req.cnt      = 2'd2;
        end else begin
          req.cnt = 2'd1;
        end
      end
      ufg_pkg::PK_E2: begin
        if (!(in_byte == ufg_pkg::B_CONT_80 && !in_last)) begin
          pcnt      = 2'd1;
          use_fresh = 1'b1;
        end
      end
      ufg_pkg::PK_E280: begin
        if (in_byte == ufg_pkg::B_LQUOTE || in_byte == ufg_pkg::B_RQUOTE) begin
          req.cnt = 2'd1;
        end else begin
          pcnt      = 2'd2;
          use_fresh = 1'b1;
        end
      end
      default: begin
        use_fresh = 1'b1;
      end
    endcase
    // broken sequences give spaces, then the byte is taken fresh
    if (use_fresh) begin
      req.chars[pcnt] = f_ch;
      req.cnt         = pcnt + {1'b0, f_has};
    end
  end

  // Next open state
  always_comb begin
    pend_nxt = ufg_pkg::PK_NONE;
    if (use_fresh && !f_has) begin
      case (in_byte)
        ufg_pkg::B_LEAD_C3: pend_nxt = ufg_pkg::PK_C3;
        ufg_pkg::B_LEAD_C5: pend_nxt = ufg_pkg::PK_C5;
        default:            pend_nxt = ufg_pkg::PK_E2;
      endcase
    end else if (pend_r == ufg_pkg::PK_E2 && in_byte == ufg_pkg::B_CONT_80 &&
                 !in_last) begin
      pend_nxt = ufg_pkg::PK_E280;
    end
  end

  assign req_push = accept && (req.cnt != 2'd0);

  // Open-sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= ufg_pkg::PK_NONE;
    end else if (accept) begin
      pend_r <= pend_nxt;
    end
  end

`ifndef SYNTH
  // a byte marked last never leaves a sequence open
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> pend_r == ufg_pkg::PK_NONE)
    else $error("sequence left open after last byte");

  // a last byte always yields a request
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |-> req_push)
    else $error("last byte gave no result");

  // open state only moves on an accepted byte
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(pend_r))
    else $error("open state changed without a byte");
`endif

endmodule

// ===== design/ufg_req_queue.sv =====
module ufg_req_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ufg_pkg::ufg_req_t  push_req,
  output logic               full,
  input  logic               pop,
  output ufg_pkg::ufg_head_t head
);

  localparam logic [ufg_pkg::QPtrW:0] CntFull = (ufg_pkg::QPtrW + 1)'(ufg_pkg::QDepth);

  ufg_pkg::ufg_req_t             ent_r [ufg_pkg::QDepth];
  logic [ufg_pkg::QPtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [ufg_pkg::QPtrW:0]       cnt_r, cnt_nxt;
  logic                          do_pop;

  assign full       = (cnt_r == CntFull);
  assign head.valid = (cnt_r != '0);
  assign head.req   = ent_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ===== design/ufg_back.sv =====
module ufg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ufg_pkg::ufg_head_t head,
  output logic               q_pop,
  output logic [6:0]         out_char_code,
  output logic [34:0]        out_glyph_bits,
  output logic               out_run_last,
  output logic               out_text_end,
  output logic               out_empty,
  input  logic               out_pop
);

  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r;
  logic [6:0]  out_char_r;
  logic [34:0] out_glyph_r;
  logic        out_run_last_r;
  logic        out_text_end_r;
  logic        load;
  logic        cur_last;
  logic [6:0]  cur_ch;

  // Next character of the head request
  assign cur_ch   = head.req.chars[idx_r];
  assign cur_last = (idx_r == head.req.cnt - 2'd1);
  assign load     = head.valid && (!out_valid_r || out_pop);
  assign q_pop    = load && cur_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = cur_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register with glyph lookup
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r     <= cur_ch;
      out_glyph_r    <= ufg_pkg::glyph_rom(cur_ch);
      out_run_last_r <= cur_last;
      out_text_end_r <= cur_last && head.req.last;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_char_code  = out_char_r;
  assign out_glyph_bits = out_glyph_r;
  assign out_run_last   = out_run_last_r;
  assign out_text_end   = out_text_end_r;

`ifndef SYNTH
  // mid-request position only while the request is still queued
  a_idx_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> head.valid)
    else $error("expansion position without request");

  // queued requests always carry at least one character
  a_req_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid |-> (head.req.cnt != 2'd0))
    else $error("empty request in queue");

  // finishing a request rewinds the position
  a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> idx_r == 2'd0)
    else $error("position not rewound");

  // end of text only on the last result of a byte
  a_end_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_text_end_r) |-> out_run_last_r)
    else $error("text end without run end");
`endif

endmodule

// ===== design/utf8_fold_glyph_generator.sv =====
// Character generator for a display: takes UTF-8 text one byte per cycle
// (push/full) and returns one folded printable character with its 5x7 glyph
// per result (empty/pop). ASCII is upper-cased, Latin-1 letters after C3 or
// C5 fold to base letters or AE/OE, curly quotes and stray bytes become
// spaces. A byte is taken in every cycle in which full is low; bytes that
// expand to two or three results are drained one result at a time by the
// back end, with the backlog absorbed by a four-request queue before full
// rises. A byte's request is written into the queue when the byte is
// accepted; its first result then goes into the glyph register once the
// output register is free.
// run_last marks the last result of a byte and text_end the last result of
// a byte pushed with in_last high; lead bytes waiting for a follower give
// no result until that follower arrives.
module utf8_fold_glyph_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        in_push,
  output logic        in_full,
  output logic [6:0]  out_char_code,
  output logic [34:0] out_glyph_bits,
  output logic        out_run_last,
  output logic        out_text_end,
  output logic        out_empty,
  input  logic        out_pop
);

  ufg_pkg::ufg_req_t  req;
  ufg_pkg::ufg_head_t head;
  logic               req_push;
  logic               q_full;
  logic               q_pop;

  // Byte classification and sequence tracking
  ufg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_push  (in_push),
    .in_full  (in_full),
    .q_full   (q_full),
    .req_push (req_push),
    .req      (req)
  );

  // Requests between the two halves
  ufg_req_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (req_push),
    .push_req (req),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head)
  );

  // Character expansion and glyph output
  ufg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_pop          (q_pop),
    .out_char_code  (out_char_code),
    .out_glyph_bits (out_glyph_bits),
    .out_run_last   (out_run_last),
    .out_text_end   (out_text_end),
    .out_empty      (out_empty),
    .out_pop        (out_pop)
  );

endmodule
